// ----- rtl/bidx_pkg.sv -----
// Shared types and widths for the bidirectional index map.
`timescale 1ns / 1ps
`default_nettype none

package bidx_pkg;

  localparam int IDX_W  = 6;
  localparam int SIZE_W = 7;
  localparam int CNT_W  = 12;
  localparam int OP_W   = 3;

  // One table entry: a valid flag plus the partner index.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } slot_t;

endpackage

`default_nettype wire

// ----- rtl/bidx_ram.sv -----
// Table memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module bidx_ram
  import bidx_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire slot_t         wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output slot_t              rdata_a,
  output slot_t              rdata_b
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/bidirectional_index_map_core.sv -----
// Top level of the bidirectional index map: forward and reverse tables with a sequencer.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a one-to-one map between keys and values in two on-chip
// tables, forward (key to value) and reverse (value to key), each entry a
// valid flag plus a 6-bit partner index. Each input item carries one
// operation (bind, erase by key, erase by value, value of key, key of value,
// swap values, swap keys) and produces exactly one result item with found,
// partner_index, the running pair count and an error flag. After reset the
// block runs a clearing pass over every entry of both tables and accepts
// no item until it ends; cfg writes are taken at any time. An item is
// accepted in IDLE, where both tables are read, and decided and written in
// EXEC. Erase by value and the swaps, once their checks pass, go on to
// READ2 (a second dependent read of the forward table) and WRITE2 (the two
// rebound pairs go through the single write port of each table one after
// the other). One item is in work at a time; a finished result sits in the
// output register, and the next item is accepted while it waits, but a
// following result holds in the block until that register drains.
// Indices at or above table_size or MAX_ENTRIES are rejected with error set.

module bidirectional_index_map_core
  import bidx_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [IDX_W-1:0]  in_first_index,
  input  wire logic [IDX_W-1:0]  in_second_index,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_found,
  output logic [IDX_W-1:0]       out_partner_index,
  output logic [CNT_W-1:0]       out_pair_count,
  output logic                   out_error,
  // size register
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_ENTRIES - 1);
  localparam logic [31:0]      MAX_U     = 32'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_BIND       = 3'd0,
    OP_ERASE_KEY  = 3'd1,
    OP_ERASE_VAL  = 3'd2,
    OP_VAL_OF_KEY = 3'd3,
    OP_KEY_OF_VAL = 3'd4,
    OP_SWAP_VALS  = 3'd5,
    OP_SWAP_KEYS  = 3'd6
  } op_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_READ2  = 6'b001000,
    ST_WRITE2 = 6'b010000,
    ST_HOLD   = 6'b100000
  } state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] partner;
    logic [CNT_W-1:0] count;
    logic             err;
  } res_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  op_t               op_r;
  logic [IDX_W-1:0]  a_r, b_r;
  // pending second pair of a swap, or the key of an erase by value
  logic [IDX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] size_r;
  res_t              res_r, res_nxt, out_r;
  logic              out_valid_r;

  logic              done, out_free, a_ok, b_ok;
  logic [CNT_W-1:0]  cnt_inc, cnt_dec;

  logic              fwd_we, rev_we;
  logic [AW-1:0]     fwd_wa, rev_wa;
  slot_t             fwd_wd, rev_wd;
  logic [AW-1:0]     fwd_ra_a, fwd_ra_b, rev_ra_a, rev_ra_b;
  slot_t             fa, fb, ra, rb;

  bidx_ram #(.DEPTH(MAX_ENTRIES)) u_fwd (
    .clk     (clk),
    .we      (fwd_we),
    .waddr   (fwd_wa),
    .wdata   (fwd_wd),
    .raddr_a (fwd_ra_a),
    .raddr_b (fwd_ra_b),
    .rdata_a (fa),
    .rdata_b (fb)
  );

  bidx_ram #(.DEPTH(MAX_ENTRIES)) u_rev (
    .clk     (clk),
    .we      (rev_we),
    .waddr   (rev_wa),
    .wdata   (rev_wd),
    .raddr_a (rev_ra_a),
    .raddr_b (rev_ra_b),
    .rdata_a (ra),
    .rdata_b (rb)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Range checks on the latched indices against both the size register and the depth.
  assign a_ok = ({1'b0, a_r} < size_r) && ({{(32-IDX_W){1'b0}}, a_r} < MAX_U);
  assign b_ok = ({1'b0, b_r} < size_r) && ({{(32-IDX_W){1'b0}}, b_r} < MAX_U);

  // Saturate the pair count at both bounds.
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_dec = (cnt_r == '0) ? cnt_r : cnt_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    res_nxt   = '{found: 1'b0, partner: '0, count: cnt_r, err: 1'b0};
    fwd_we    = 1'b0;
    fwd_wa    = AW'(a_r);
    fwd_wd    = '0;
    rev_we    = 1'b0;
    rev_wa    = AW'(b_r);
    rev_wd    = '0;
    // Read both tables at both incoming indices; the data lands in EXEC.
    fwd_ra_a  = AW'(in_first_index);
    fwd_ra_b  = AW'(in_second_index);
    rev_ra_a  = AW'(in_first_index);
    rev_ra_b  = AW'(in_second_index);

    case (state_r)
      ST_CLEAR: begin
        fwd_we = 1'b1;
        fwd_wa = clr_r;
        rev_we = 1'b1;
        rev_wa = clr_r;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // Erase by value chases the key found in the reverse table.
        fwd_ra_a = AW'(ra.idx);
        case (op_r)
          OP_BIND: begin
            done = 1'b1;
            if (!a_ok || !b_ok) begin
              res_nxt.err = 1'b1;
            end else begin
              fwd_we  = 1'b1;
              fwd_wa  = AW'(a_r);
              fwd_wd  = '{valid: 1'b1, idx: b_r};
              rev_we  = 1'b1;
              rev_wa  = AW'(b_r);
              rev_wd  = '{valid: 1'b1, idx: a_r};
              cnt_nxt = cnt_inc;
            end
          end
          OP_ERASE_KEY: begin
            done = 1'b1;
            if (!a_ok || !fa.valid) begin
              res_nxt.err = 1'b1;
            end else begin
              fwd_we  = 1'b1;
              fwd_wa  = AW'(a_r);
              rev_we  = 1'b1;
              rev_wa  = AW'(fa.idx);
              cnt_nxt = cnt_dec;
            end
          end
          OP_ERASE_VAL: begin
            if (!a_ok || !ra.valid) begin
              done        = 1'b1;
              res_nxt.err = 1'b1;
            end else begin
              x_nxt     = ra.idx;
              state_nxt = ST_READ2;
            end
          end
          OP_VAL_OF_KEY: begin
            done = 1'b1;
            if (!a_ok) begin
              res_nxt.err = 1'b1;
            end else if (fa.valid) begin
              res_nxt.found   = 1'b1;
              res_nxt.partner = fa.idx;
            end
          end
          OP_KEY_OF_VAL: begin
            done = 1'b1;
            if (!a_ok) begin
              res_nxt.err = 1'b1;
            end else if (ra.valid) begin
              res_nxt.found   = 1'b1;
              res_nxt.partner = ra.idx;
            end
          end
          OP_SWAP_VALS: begin
            if (!a_ok || !b_ok || !fa.valid || !fb.valid) begin
              done        = 1'b1;
              res_nxt.err = 1'b1;
            end else begin
              // Rebind the first key to the second value now, the other pair next.
              fwd_we    = 1'b1;
              fwd_wa    = AW'(a_r);
              fwd_wd    = '{valid: 1'b1, idx: fb.idx};
              rev_we    = 1'b1;
              rev_wa    = AW'(fb.idx);
              rev_wd    = '{valid: 1'b1, idx: a_r};
              x_nxt     = b_r;
              y_nxt     = fa.idx;
              state_nxt = ST_WRITE2;
            end
          end
          OP_SWAP_KEYS: begin
            if (!a_ok || !b_ok || !ra.valid || !rb.valid) begin
              done        = 1'b1;
              res_nxt.err = 1'b1;
            end else begin
              fwd_we    = 1'b1;
              fwd_wa    = AW'(ra.idx);
              fwd_wd    = '{valid: 1'b1, idx: b_r};
              rev_we    = 1'b1;
              rev_wa    = AW'(b_r);
              rev_wd    = '{valid: 1'b1, idx: ra.idx};
              x_nxt     = rb.idx;
              y_nxt     = a_r;
              state_nxt = ST_WRITE2;
            end
          end
          default: begin
            done        = 1'b1;
            res_nxt.err = 1'b1;
          end
        endcase
      end

      ST_READ2: begin
        // fa now holds the forward entry of the key found by erase by value.
        done = 1'b1;
        if (!fa.valid) begin
          res_nxt.err = 1'b1;
        end else begin
          fwd_we  = 1'b1;
          fwd_wa  = AW'(x_r);
          rev_we  = 1'b1;
          rev_wa  = AW'(fa.idx);
          cnt_nxt = cnt_dec;
        end
      end

      ST_WRITE2: begin
        done   = 1'b1;
        fwd_we = 1'b1;
        fwd_wa = AW'(x_r);
        fwd_wd = '{valid: 1'b1, idx: y_r};
        rev_we = 1'b1;
        rev_wa = AW'(y_r);
        rev_wd = '{valid: 1'b1, idx: x_r};
      end

      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res_nxt.count = cnt_nxt;
    // Park the result when the output register is still occupied.
    if (done) begin
      state_nxt = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      size_r      <= SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (done && out_free) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == ST_HOLD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: item fields, pending pair and result.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    if (in_valid && in_ready) begin
      op_r <= op_t'(in_operation);
      a_r  <= in_first_index;
      b_r  <= in_second_index;
    end
    if (done) begin
      res_r <= res_nxt;
    end
    if (done && out_free) begin
      out_r <= res_nxt;
    end else if ((state_r == ST_HOLD) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_r.found;
  assign out_partner_index = out_r.partner;
  assign out_pair_count    = out_r.count;
  assign out_error         = out_r.err;

endmodule

`default_nettype wire

// ----- tb/bidirectional_index_map_checker.sv -----
// Operation codes and the scoreboard that predicts and checks the bidirectional index map.
`timescale 1ns / 1ps

package bidx_tb_pkg;

  typedef enum logic [bidx_pkg::OP_W-1:0] {
    OP_BIND         = 3'd0,
    OP_ERASE_KEY    = 3'd1,
    OP_ERASE_VALUE  = 3'd2,
    OP_VALUE_OF_KEY = 3'd3,
    OP_KEY_OF_VALUE = 3'd4,
    OP_SWAP_VALUES  = 3'd5,
    OP_SWAP_KEYS    = 3'd6,
    OP_RESERVED     = 3'd7
  } map_op_t;

endpackage

module bidirectional_index_map_checker
  import bidx_pkg::*;
  import bidx_tb_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]  in_first_index,
  input  logic [IDX_W-1:0]  in_second_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_found,
  input  logic [IDX_W-1:0]  out_partner_index,
  input  logic [CNT_W-1:0]  out_pair_count,
  input  logic              out_error,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                mismatch_count,
  output int                pending_count,
  output int                checked_count,
  output int                error_results,
  output logic [CNT_W-1:0]  peak_pairs
);

  localparam logic [CNT_W-1:0] PAIRS_TOP = {CNT_W{1'b1}};

  typedef struct {
    map_op_t          op;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic             found;
    logic [IDX_W-1:0] partner;
    logic [CNT_W-1:0] pairs;
    logic             error;
  } map_result_t;

  slot_t            key_to_value [MAX_ENTRIES];
  slot_t            value_to_key [MAX_ENTRIES];
  logic [CNT_W-1:0] pairs_now;
  logic [SIZE_W-1:0] size_now;
  map_result_t      expected_results [$];
  map_result_t      oldest;

  function automatic logic index_ok(input logic [IDX_W-1:0] i);
    return ({1'b0, i} < size_now) && (int'(i) < MAX_ENTRIES);
  endfunction

  function automatic void link_pair(input logic [IDX_W-1:0] k, input logic [IDX_W-1:0] v);
    key_to_value[k] = '{valid: 1'b1, idx: v};
    value_to_key[v] = '{valid: 1'b1, idx: k};
  endfunction

  // Empty the forward entry of k and the reverse entry it points at.
  function automatic logic unlink_key(input logic [IDX_W-1:0] k);
    if (!key_to_value[k].valid) return 1'b0;
    value_to_key[key_to_value[k].idx].valid = 1'b0;
    key_to_value[k].valid = 1'b0;
    if (pairs_now != '0) pairs_now = pairs_now - 1'b1;
    return 1'b1;
  endfunction

  function automatic map_result_t apply_map_op(input map_op_t op, input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    map_result_t      r;
    logic [IDX_W-1:0] p1;
    logic [IDX_W-1:0] p2;
    r = '{op: op, first: a, second: b, found: 1'b0, partner: '0, pairs: '0, error: 1'b0};
    case (op)
      OP_BIND: begin
        if (!index_ok(a) || !index_ok(b)) begin
          r.error = 1'b1;
        end else begin
          link_pair(a, b);
          if (pairs_now != PAIRS_TOP) pairs_now = pairs_now + 1'b1;
        end
      end
      OP_ERASE_KEY: begin
        if (!index_ok(a)) r.error = 1'b1;
        else if (!unlink_key(a)) r.error = 1'b1;
      end
      OP_ERASE_VALUE: begin
        if (!index_ok(a) || !value_to_key[a].valid) r.error = 1'b1;
        else if (!unlink_key(value_to_key[a].idx)) r.error = 1'b1;
      end
      OP_VALUE_OF_KEY: begin
        if (!index_ok(a)) begin
          r.error = 1'b1;
        end else if (key_to_value[a].valid) begin
          r.found   = 1'b1;
          r.partner = key_to_value[a].idx;
        end
      end
      OP_KEY_OF_VALUE: begin
        if (!index_ok(a)) begin
          r.error = 1'b1;
        end else if (value_to_key[a].valid) begin
          r.found   = 1'b1;
          r.partner = value_to_key[a].idx;
        end
      end
      OP_SWAP_VALUES: begin
        if (!index_ok(a) || !index_ok(b) ||
            !key_to_value[a].valid || !key_to_value[b].valid) begin
          r.error = 1'b1;
        end else begin
          p1 = key_to_value[a].idx;
          p2 = key_to_value[b].idx;
          link_pair(a, p2);
          link_pair(b, p1);
        end
      end
      OP_SWAP_KEYS: begin
        if (!index_ok(a) || !index_ok(b) ||
            !value_to_key[a].valid || !value_to_key[b].valid) begin
          r.error = 1'b1;
        end else begin
          p1 = value_to_key[a].idx;
          p2 = value_to_key[b].idx;
          link_pair(p1, b);
          link_pair(p2, a);
        end
      end
      default: r.error = 1'b1;
    endcase
    r.pairs = pairs_now;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        key_to_value[i] = '0;
        value_to_key[i] = '0;
      end
      pairs_now      = '0;
      size_now       = SIZE_W'(64);
      peak_pairs     = '0;
      mismatch_count = 0;
      checked_count  = 0;
      error_results  = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("mismatch: result with nothing outstanding (count=%0d error=%0b)",
                     out_pair_count, out_error);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          checked_count++;
          if (out_error) error_results++;
          if (out_found !== oldest.found || out_partner_index !== oldest.partner ||
              out_pair_count !== oldest.pairs || out_error !== oldest.error) begin
            if (mismatch_count < 10) begin
              $write("mismatch: %s a=%0d b=%0d expected found=%0b partner=%0d count=%0d ",
                     oldest.op.name(), oldest.first, oldest.second, oldest.found,
                     oldest.partner, oldest.pairs);
              $display("error=%0b, got found=%0b partner=%0d count=%0d error=%0b",
                       oldest.error, out_found, out_partner_index, out_pair_count,
                       out_error);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_map_op(map_op_t'(in_operation), in_first_index,
                                                in_second_index));
        if (pairs_now > peak_pairs) peak_pairs = pairs_now;
      end
      if (cfg_we) size_now = cfg_wdata;
    end
    pending_count = expected_results.size();
  end

endmodule

// ----- tb/bidirectional_index_map_core_tb.sv -----
// Stimulus, handshake pacing and verdict for the bidirectional index map core.
`timescale 1ns / 1ps

module bidirectional_index_map_core_tb;
  import bidx_pkg::*;
  import bidx_tb_pkg::*;

  localparam int MAX_ENTRIES   = 64;
  localparam logic [IDX_W-1:0] IDX_TOP = '1;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_PHASES    = 10;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int TAIL_BINDS    = 150;
  // Size register per random phase; the random slot is drawn at run time.
  localparam int PHASE_SIZES [NUM_PHASES] = '{64, 4, 127, 1, 0, 64, 16, 2, 32, 40};
  localparam int RANDOM_SLOT   = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [IDX_W-1:0]  in_first_index;
  logic [IDX_W-1:0]  in_second_index;
  logic              out_valid;
  logic              out_ready;
  logic              out_found;
  logic [IDX_W-1:0]  out_partner_index;
  logic [CNT_W-1:0]  out_pair_count;
  logic              out_error;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  int                mismatch_count;
  int                pending_count;
  int                checked_count;
  int                error_results;
  logic [CNT_W-1:0]  peak_pairs;

  // Pacing controls shared between the sender and the receiver.
  bit                calm;
  bit                hold_request;
  int                stall_left;
  int                items_sent;
  int                settings_used;
  int                quiet_cycles;

  bidirectional_index_map_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_first_index   (in_first_index),
    .in_second_index  (in_second_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_partner_index(out_partner_index),
    .out_pair_count   (out_pair_count),
    .out_error        (out_error),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  bidirectional_index_map_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_first_index   (in_first_index),
    .in_second_index  (in_second_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_partner_index(out_partner_index),
    .out_pair_count   (out_pair_count),
    .out_error        (out_error),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .error_results    (error_results),
    .peak_pairs       (peak_pairs)
  );

  // 10 ns clock, rising edge at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: end the run if neither channel moves an item for too long. The
  // longest legal quiet stretch is the receiver's long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_count);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off on
  // request, and no stalls at all once the run turns calm.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high on
  // return so that a back-to-back item follows without a drop in between.
  task automatic send_op(input map_op_t op, input logic [IDX_W-1:0] a,
                         input logic [IDX_W-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap      = $urandom_range(1, 18);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_operation    = op;
    in_first_index  = a;
    in_second_index = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has been checked.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Write the size register with the block idle.
  task automatic write_size(input logic [SIZE_W-1:0] size_value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = size_value;
    settings_used++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly in-range indices for the current size, with some anywhere.
  function automatic logic [IDX_W-1:0] pick_index(input logic [SIZE_W-1:0] size_value);
    if (size_value == 0 || size_value >= MAX_ENTRIES || $urandom_range(0, 9) == 0)
      return IDX_W'($urandom_range(0, IDX_TOP));
    return IDX_W'($urandom_range(0, size_value - 1));
  endfunction

  initial begin
    logic [SIZE_W-1:0] size_value;
    map_op_t           op;
    int                pick;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_BIND;
    in_first_index  = '0;
    in_second_index = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    calm            = 1'b0;
    hold_request    = 1'b0;
    items_sent      = 0;
    settings_used   = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty lookups, binds at the index extremes, both swaps,
    // rejected erases and swaps on empty entries, the unused code, and an
    // erase by value whose key was already emptied.
    write_size(SIZE_W'(MAX_ENTRIES));
    send_op(OP_VALUE_OF_KEY, 0, 0);
    send_op(OP_KEY_OF_VALUE, IDX_TOP, 0);
    send_op(OP_BIND, 0, IDX_TOP);
    send_op(OP_BIND, IDX_TOP, 0);
    send_op(OP_VALUE_OF_KEY, 0, 0);
    send_op(OP_KEY_OF_VALUE, 0, IDX_TOP);
    send_op(OP_SWAP_VALUES, 0, IDX_TOP);
    send_op(OP_SWAP_KEYS, 0, IDX_TOP);
    send_op(OP_SWAP_VALUES, 0, 5);
    send_op(OP_SWAP_KEYS, 1, 0);
    send_op(OP_ERASE_KEY, 7, 0);
    send_op(OP_ERASE_VALUE, 7, 0);
    send_op(OP_RESERVED, IDX_TOP, IDX_TOP);
    send_op(OP_BIND, 5, 5);
    send_op(OP_BIND, 5, 6);
    send_op(OP_ERASE_KEY, 5, 0);
    send_op(OP_ERASE_VALUE, 5, 0);
    send_op(OP_ERASE_KEY, IDX_TOP, 0);
    send_op(OP_ERASE_VALUE, IDX_TOP, 0);

    // Out-of-range indices at the smallest sizes, then the widest register value.
    write_size(SIZE_W'(1));
    send_op(OP_BIND, 0, 0);
    send_op(OP_BIND, 1, 0);
    send_op(OP_VALUE_OF_KEY, 1, 0);
    write_size('0);
    send_op(OP_KEY_OF_VALUE, 0, 0);
    send_op(OP_ERASE_KEY, 0, 0);
    write_size({SIZE_W{1'b1}});
    send_op(OP_BIND, IDX_TOP, IDX_TOP);

    // Random phases, one size setting each. Each phase opens with binds so
    // that erases, lookups and swaps find populated entries.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      size_value = (ph == RANDOM_SLOT) ? SIZE_W'($urandom_range(1, MAX_ENTRIES))
                                       : SIZE_W'(PHASE_SIZES[ph]);
      write_size(size_value);
      // First phase: stall the receiver for a long stretch while items keep
      // coming, so the block backs up and drops in_ready.
      if (ph == 0) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (n < 12 || pick < 26) op = OP_BIND;
        else if (pick < 38) op = OP_ERASE_KEY;
        else if (pick < 50) op = OP_ERASE_VALUE;
        else if (pick < 62) op = OP_VALUE_OF_KEY;
        else if (pick < 74) op = OP_KEY_OF_VALUE;
        else if (pick < 86) op = OP_SWAP_VALUES;
        else if (pick < 97) op = OP_SWAP_KEYS;
        else op = OP_RESERVED;
        send_op(op, pick_index(size_value), pick_index(size_value));
      end
    end

    // Calm tail: no stalls on either side; a run of binds back to back,
    // then a short random mix of every code.
    write_size(SIZE_W'(MAX_ENTRIES));
    calm = 1'b1;
    repeat (TAIL_BINDS) begin
      send_op(OP_BIND, pick_index(SIZE_W'(MAX_ENTRIES)), pick_index(SIZE_W'(MAX_ENTRIES)));
    end
    repeat (24) begin
      op = map_op_t'($urandom_range(0, 7));
      send_op(op, pick_index(SIZE_W'(MAX_ENTRIES)), pick_index(SIZE_W'(MAX_ENTRIES)));
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("summary: %0d items across %0d size settings, %0d results checked, %0d flagged error",
             items_sent, settings_used, checked_count, error_results);
    $display("summary: pair count peaked at %0d, %0d mismatches", peak_pairs, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
